// ===== sv/mrlc_pkg.sv =====
package mrlc_pkg;

    localparam int NumEntries = 64;
    localparam int MaxLen     = 20;
    localparam int PosW       = 5;
    localparam int PosSpan    = 2 ** PosW;
    localparam int CodeW      = 6;

    typedef logic [MaxLen*8-1:0] t_text;
    typedef logic [CodeW-1:0]    t_code;
    typedef logic [PosW-1:0]     t_pos;

    // per-word control from the top level to the matcher
    typedef struct packed {
        logic step;   // word consumed this cycle
        logic last;   // it is the final word of the line
    } t_ctl;

    localparam logic [7:0] CharComma  = 8'h2C;
    localparam t_code      CodeNone   = 6'd0;
    localparam t_code      CodeNwGsm  = 6'd18;
    localparam t_code      CodeNwGprs = 6'd19;
    localparam t_code      CodeMax    = 6'd61;

    // prefixes, right-justified, zero-padded on the left
    localparam t_text EntryText [NumEntries] = '{
        "AT", "OK", "ERROR", "+CMS ERROR",
        "+CME ERROR", "+QIOPEN: ", "+QIACT: ", "SOC_\105STB",
        "SRV_ACK", "SEND OK", "DEACT OK", "+QSSLOPEN: ",
        "+CPIN:", "+COPS:", "+QSPN:", "+QNWINFO:",
        "+CFUN:", "+CREG:", "+CGREG:", "+QENG:",
        "+CSQ:", "+QIRD:", "+CCLK:",
        "STATE: IP INITIAL", "STATE: IP START",
        "STATE: IP CONFIG", "STATE: IP IND",
        "STATE: IP GPRSACT", "STATE: IP STATUS",
        "STATE: IP PROCESSING", "STATE: PDP DEACT",
        "+QISTATE:", "CONNECT FAIL", "0, CONNECT FAIL",
        "1, CONNECT FAIL", "0, CLOSE OK", "1, CLOSE OK",
        "+CMGS:", "+CMGR:", "+CMGL:", "SHUT OK",
        "SEND FAIL", "ALREADY CONNECT", "BUSY",
        "RING", "NO CARRIER", "+PPSTIR", "PN",
        "PY", "NO ANSWER", "PD",
        "STATE: CONNECT OK", "STATE: IP CLOSE",
        "+QFLDS: ", "+QFTPCFG:", "+QFTPOPEN:",
        "+QFTPCWD:", "+QFTPSIZE:", "+QFTPGET:",
        "+QFTPCLOSE:", "+QFLST: ", "+QFOPEN: ",
        "CONNECT ", "POWERED DOWN"
    };

    localparam t_code EntryCode [NumEntries] = '{
        6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,
        6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16,
        6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
        6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
        6'd33, 6'd33, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38,
        6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd1,  6'd45,
        6'd46, 6'd47, 6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53,
        6'd54, 6'd55, 6'd56, 6'd57, 6'd58, 6'd59, 6'd60, 6'd61
    };

    // prefix length: count of non-zero bytes
    function automatic int text_len(input int e);
        t_text t;
        int    n;
        t = EntryText[e];
        n = 0;
        for (int k = 0; k < MaxLen; k++) begin
            if (t[k*8 +: 8] != 8'h00) n++;
        end
        return n;
    endfunction

    // character k of prefix e, counted from the start of the line
    function automatic logic [7:0] text_char(input int e, input int k);
        t_text t;
        int    l;
        t = EntryText[e];
        l = text_len(e);
        if (k < l) return t[(l-1-k)*8 +: 8];
        return 8'h00;
    endfunction

endpackage

// ===== sv/modem_response_line_classifier.sv =====
// Modem response line classifier.
// Input channel: one line character per word on i_line_byte, with i_line_end
// high on the final character. A word is taken at a clock edge where i_valid
// is high and o_stall is low.
// Output channel: one word per line, o_response_code, 0 for no match or the
// code of the first prefix in the table that the line starts with. Taken at
// an edge where o_valid is high and i_stall is low.
// A +CREG/+CGREG code (18, 19) gives 0 if the line holds no comma. A final
// character waits in the input register, is compared there against every
// prefix, and its code goes into the result register. Throughput: one
// character per cycle while o_stall is low, set by the single compare stage
// that checks all 64 prefixes in parallel against the registered byte.
// Reset (i_rst_n low at a clock edge): all prefixes alive, position and comma
// flag cleared, both stages empty; the same clearing follows every line end.
// Receiver stall: the result word holds. Characters that end no line still
// drain through; a final character waits in the input register, and o_stall
// rises, until the result register frees up.
module modem_response_line_classifier (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_line_byte,
    input  logic                  i_line_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [5:0]            o_response_code
);

    // input register
    logic                  r_s1_vld;
    logic [7:0]            r_s1_byte;
    logic                  r_s1_end;

    // line state
    mrlc_pkg::t_pos        r_pos;
    mrlc_pkg::t_pos        n_pos;
    logic                  r_comma;
    logic                  n_comma;

    // result register
    logic                  r_out_vld;
    mrlc_pkg::t_code       r_code;

    logic                  s1_step;
    logic                  comma_any;
    mrlc_pkg::t_ctl        ctl;
    logic [mrlc_pkg::NumEntries-1:0] match;
    mrlc_pkg::t_code       code;

    // a non-final char never needs the result register
    assign s1_step   = r_s1_vld & (~r_s1_end | ~r_out_vld | ~i_stall);
    assign o_stall   = r_s1_vld & ~s1_step;
    assign comma_any = r_comma | (r_s1_byte == mrlc_pkg::CharComma);

    assign ctl.step  = s1_step;
    assign ctl.last  = r_s1_end;

    mrlc_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_byte  (r_s1_byte),
        .i_pos   (r_pos),
        .o_match (match)
    );

    mrlc_prio u_prio (
        .i_match (match),
        .i_comma (comma_any),
        .o_code  (code)
    );

    // position saturates at its top code; only the comma check cares past 20
    always_comb begin
        n_pos   = r_pos;
        n_comma = r_comma;
        if (s1_step) begin
            if (r_s1_end) begin
                n_pos   = '0;
                n_comma = 1'b0;
            end else begin
                n_comma = comma_any;
                if (r_pos != '1) n_pos = r_pos + mrlc_pkg::PosW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_pos     <= '0;
            r_comma   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_stall) r_s1_vld <= i_valid;
            r_pos   <= n_pos;
            r_comma <= n_comma;
            if (s1_step && r_s1_end) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_s1_byte <= i_line_byte;
            r_s1_end  <= i_line_end;
        end
        if (s1_step && r_s1_end) r_code <= code;
    end

    assign o_valid         = r_out_vld;
    assign o_response_code = r_code;

    // stall only when a final char is blocked by a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_end && r_out_vld && i_stall))
        else $error("input stalled without a blocked result");

    // line state restarts after every line end
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_step && r_s1_end) |=> (r_pos == '0 && !r_comma))
        else $error("line state not cleared after line end");

    // a new result only comes from a consumed final char
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(s1_step && r_s1_end))
        else $error("result appeared without a line end");

    // code range
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_response_code <= mrlc_pkg::CodeMax))
        else $error("response code out of range");

endmodule

// ===== sv/mrlc_match.sv =====
module mrlc_match (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mrlc_pkg::t_ctl                   i_ctl,
    input  logic [7:0]                       i_byte,
    input  mrlc_pkg::t_pos                   i_pos,
    output logic [mrlc_pkg::NumEntries-1:0]  o_match
);

    logic [mrlc_pkg::NumEntries-1:0] r_alive;
    logic [mrlc_pkg::NumEntries-1:0] n_alive;
    logic [mrlc_pkg::NumEntries-1:0] alive_upd;

    for (genvar i = 0; i < mrlc_pkg::NumEntries; i++) begin : g_ent
        localparam mrlc_pkg::t_pos Len = mrlc_pkg::PosW'(mrlc_pkg::text_len(i));
        logic [mrlc_pkg::PosSpan-1:0] char_ok;

        for (genvar k = 0; k < mrlc_pkg::PosSpan; k++) begin : g_chr
            assign char_ok[k] = (i_byte == mrlc_pkg::text_char(i, k));
        end

        assign alive_upd[i] = r_alive[i] & ~((i_pos < Len) & ~char_ok[i_pos]);
        // whole prefix covered: pos + 1 >= len
        assign o_match[i]   = alive_upd[i] & (i_pos >= Len - mrlc_pkg::PosW'(1));
    end

    always_comb begin
        n_alive = r_alive;
        if (i_ctl.step) begin
            n_alive = i_ctl.last ? '1 : alive_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '1;
        end else begin
            r_alive <= n_alive;
        end
    end

endmodule

// ===== sv/mrlc_prio.sv =====
module mrlc_prio (
    input  logic [mrlc_pkg::NumEntries-1:0] i_match,
    input  logic                            i_comma,
    output mrlc_pkg::t_code                 o_code
);

    mrlc_pkg::t_code first_code;
    logic            found;

    // first entry in table order wins
    always_comb begin
        first_code = mrlc_pkg::CodeNone;
        found      = 1'b0;
        for (int i = 0; i < mrlc_pkg::NumEntries; i++) begin
            if (!found && i_match[i]) begin
                found      = 1'b1;
                first_code = mrlc_pkg::EntryCode[i];
            end
        end
    end

    // registration reports need a comma
    always_comb begin
        o_code = first_code;
        if ((first_code == mrlc_pkg::CodeNwGsm || first_code == mrlc_pkg::CodeNwGprs)
            && !i_comma) begin
            o_code = mrlc_pkg::CodeNone;
        end
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;

    typedef logic [7:0] t_char;

    // one directed line: its text, where to slip in a NUL byte, and the code
    // it must give (ByPredictor: take the code from the line classifier below)
    typedef struct {
        string text;
        int    nul_at;
        int    code;
    } t_row;

    localparam int    NumPrefixes = 64;
    localparam int    ByPredictor = -1;
    localparam int    NoNul       = -1;
    localparam int    RegGsmCode  = 18;
    localparam int    RegGprsCode = 19;
    localparam int    CregIdx     = 17;
    localparam int    CgregIdx    = 18;
    localparam int    PosTop      = 31;
    localparam t_char CommaChar   = 8'h2C;
    localparam t_char NulChar     = 8'h00;
    localparam int    PhaseChars  = 160;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_line_byte = 8'h00;
    logic        i_line_end = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [5:0]  o_response_code;

    modem_response_line_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_line_byte     (i_line_byte),
        .i_line_end      (i_line_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_response_code (o_response_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Prefix table, in priority order, with the dense response codes.
    string prefix_text [NumPrefixes] = '{
        "AT", "OK", "ERROR", "+CMS ERROR",
        "+CME ERROR", "+QIOPEN: ", "+QIACT: ", "SOC_\105STB",
        "SRV_ACK", "SEND OK", "DEACT OK", "+QSSLOPEN: ",
        "+CPIN:", "+COPS:", "+QSPN:", "+QNWINFO:",
        "+CFUN:", "+CREG:", "+CGREG:", "+QENG:",
        "+CSQ:", "+QIRD:", "+CCLK:",
        "STATE: IP INITIAL", "STATE: IP START",
        "STATE: IP CONFIG", "STATE: IP IND",
        "STATE: IP GPRSACT", "STATE: IP STATUS",
        "STATE: IP PROCESSING", "STATE: PDP DEACT",
        "+QISTATE:", "CONNECT FAIL", "0, CONNECT FAIL",
        "1, CONNECT FAIL", "0, CLOSE OK", "1, CLOSE OK",
        "+CMGS:", "+CMGR:", "+CMGL:", "SHUT OK",
        "SEND FAIL", "ALREADY CONNECT", "BUSY",
        "RING", "NO CARRIER", "+PPSTIR", "PN",
        "PY", "NO ANSWER", "PD",
        "STATE: CONNECT OK", "STATE: IP CLOSE",
        "+QFLDS: ", "+QFTPCFG:", "+QFTPOPEN:",
        "+QFTPCWD:", "+QFTPSIZE:", "+QFTPGET:",
        "+QFTPCLOSE:", "+QFLST: ", "+QFOPEN: ",
        "CONNECT ", "POWERED DOWN"
    };

    int prefix_code [NumPrefixes] = '{
        1,  2,  3,  4,  5,  6,  7,  8,  9,  10, 11, 12, 13, 14, 15, 16,
        17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32,
        33, 33, 33, 34, 35, 36, 37, 38, 39, 40, 41, 42, 43, 44, 1,  45,
        46, 47, 48, 49, 50, 51, 52, 53, 54, 55, 56, 57, 58, 59, 60, 61
    };

    // Directed lines. Codes typed in where they are obvious; the rest go
    // through the line classifier.
    t_row directed_rows [] = '{
        '{"AT", NoNul, 1},
        '{"OK", NoNul, 2},
        '{"ERROR", NoNul, 3},
        '{"+CME ERROR: 10", NoNul, 5},
        '{"+CREG: 0", NoNul, 0},                 // registration, no comma
        '{"+CREG: 0,1", NoNul, 18},
        '{"+CGREG: 2", NoNul, 0},                // GPRS registration, no comma
        '{"+CGREG: 0,5", NoNul, 19},
        '{"+CREG: 1,5", 8, 18},                  // NUL mid-line, comma after it
        '{"", 0, 0},                             // lone NUL byte
        '{"STATE: IP PROCESSING", NoNul, 30},    // longest prefix, exact
        '{"STATE: IP PROCESSIN", NoNul, ByPredictor},
        '{"0, CONNECT FAIL", NoNul, 33},
        '{"CONNECT FAIL", NoNul, 33},
        '{"CONNECT 9600", NoNul, 60},
        '{"CONNECT", NoNul, ByPredictor},        // one short of "CONNECT "
        '{"+PPSTIR", NoNul, 1},
        '{"POWERED DOWN", NoNul, 61},
        '{"PN", NoNul, ByPredictor},
        '{"A", NoNul, 0},                        // one-byte line
        '{"\377", NoNul, 0},
        '{"AT\377\001", NoNul, 1},
        '{"SEND FAIL", NoNul, 40},
        // position saturates; the comma past it still counts
        '{"+CREG: 2                              ,7", NoNul, 18},
        '{"+CGREG: 1 with a long tail and never a comma", NoNul, 0}
    };

    // Line classifier state
    logic [NumPrefixes-1:0] prefix_alive = '1;
    logic [4:0]             line_pos = '0;
    logic                   saw_comma = 1'b0;

    mrlc_pkg::t_code expected_codes [$];
    int    mismatches = 0;
    int    chars_taken = 0;
    int    send_idle_pct = 15;
    int    recv_stall_pct = 74;

    // Advance the classifier by one character. Returns the response code on
    // the final character of a line, ByPredictor otherwise.
    function automatic int classify_char(input t_char c, input logic fin);
        int len;
        int code;
        int count;
        logic found;
        code = ByPredictor;
        for (int i = 0; i < NumPrefixes; i++) begin
            len = prefix_text[i].len();
            if (int'(line_pos) < len && t_char'(prefix_text[i][line_pos]) != c)
                prefix_alive[i] = 1'b0;
        end
        if (c == CommaChar)
            saw_comma = 1'b1;
        if (!fin) begin
            if (int'(line_pos) < PosTop)
                line_pos = line_pos + 5'd1;
        end else begin
            count = int'(line_pos) + 1;
            code = 0;
            found = 1'b0;
            // first live prefix that fits in the line wins
            for (int i = 0; i < NumPrefixes; i++) begin
                if (!found && prefix_alive[i] && prefix_text[i].len() <= count) begin
                    found = 1'b1;
                    code = prefix_code[i];
                    if ((code == RegGsmCode || code == RegGprsCode) && !saw_comma)
                        code = 0;
                end
            end
            prefix_alive = '1;
            line_pos = '0;
            saw_comma = 1'b0;
        end
        return code;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    // Send one character word; entered and left just after a falling edge.
    // i_valid is assigned at most once per falling edge.
    task automatic push_char(input t_char c, input logic fin, input int fixed);
        int code;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_line_byte <= c;
        i_line_end  <= fin;
        do @(posedge i_clk); while (o_stall);
        chars_taken++;
        code = classify_char(c, fin);
        if (fin)
            expected_codes.push_back(mrlc_pkg::t_code'((fixed >= 0) ? fixed : code));
        @(negedge i_clk);
    endtask

    task automatic send_line(input t_char chars [$], input int fixed);
        for (int k = 0; k < chars.size(); k++)
            push_char(chars[k], k == chars.size() - 1, fixed);
    endtask

    // Receiver back-pressure
    always @(negedge i_clk)
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Result checker: outputs sampled at the rising edge, before they update.
    always @(posedge i_clk) begin
        mrlc_pkg::t_code want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_codes.size() == 0) begin
                report_mismatch($sformatf("code %0d with no line pending",
                                          o_response_code));
            end else begin
                want = expected_codes.pop_front();
                if (o_response_code !== want)
                    report_mismatch($sformatf("response_code %0d, wanted %0d",
                                              o_response_code, want));
            end
        end
    end

    initial begin
        t_char chars [$];
        int    kind;
        int    pick;
        int    keep;
        int    tail_len;
        int    goal;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines
        foreach (directed_rows[r]) begin
            chars.delete();
            for (int k = 0; k < directed_rows[r].text.len(); k++)
                chars.push_back(t_char'(directed_rows[r].text[k]));
            if (directed_rows[r].nul_at >= 0)
                chars.insert(directed_rows[r].nul_at, NulChar);
            send_line(chars, directed_rows[r].code);
        end

        // random lines in three idling phases: sender light / receiver heavy,
        // then swapped, then no idling at all
        goal = chars_taken;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 74;
                end
                1: begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 15;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            goal += PhaseChars;
            while (chars_taken < goal) begin
                chars.delete();
                kind = $urandom_range(0, 9);
                if (kind < 8) begin
                    // a real prefix, registration lines favored, then a tail
                    pick = ($urandom_range(0, 4) == 0) ?
                           ($urandom_range(0, 1) ? CgregIdx : CregIdx) :
                           $urandom_range(0, NumPrefixes - 1);
                    for (int k = 0; k < prefix_text[pick].len(); k++)
                        chars.push_back(t_char'(prefix_text[pick][k]));
                    if (kind == 7) begin
                        // broken prefix: cut short or one character hit
                        if ($urandom_range(0, 1)) begin
                            keep = $urandom_range(1, chars.size());
                            while (chars.size() > keep)
                                void'(chars.pop_back());
                        end else begin
                            chars[$urandom_range(0, chars.size() - 1)] =
                                t_char'($urandom_range(1, 255));
                        end
                    end
                    tail_len = ($urandom_range(0, 9) == 0) ?
                               $urandom_range(10, 40) : $urandom_range(0, 8);
                    repeat (tail_len) begin
                        case ($urandom_range(0, 3))
                            0: chars.push_back(CommaChar);
                            1: chars.push_back(t_char'($urandom_range(1, 255)));
                            default: chars.push_back(t_char'($urandom_range(32, 122)));
                        endcase
                    end
                end else begin
                    // line noise
                    repeat ($urandom_range(1, 6))
                        chars.push_back(t_char'($urandom_range(1, 255)));
                end
                send_line(chars, ByPredictor);
            end
        end

        i_valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge i_clk);
        // a stray extra result would show within the pipeline depth
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && expected_codes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/mrlc_pkg.sv
sv/mrlc_match.sv
sv/mrlc_prio.sv
sv/modem_response_line_classifier.sv
verif/testbench.sv
